FILE: design/teh_pkg.sv
// Shared types, constants and helper functions of the toroidal edge histogram.
// Used by the channel interfaces, the top level and its checker; depends on nothing.
`timescale 1ns / 1ps

package teh_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int BUCKETS    = 256;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int BKT_W = $clog2(BUCKETS);

	localparam int PIX_W     = 8;
	localparam int IDX_W     = 8;
	localparam int CNT_W     = 22;
	localparam int LEN_W     = 9;
	localparam int DIM_W     = 11;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 2;
	localparam int PAIRS     = 4;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_PIXEL = 2'd0,
		REQ_READ  = 2'd1,
		REQ_START = 2'd2
	} req_t;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

	typedef logic signed [PIX_W-1:0] pix_t;

	// True when pos is the last position of a dimension of the given size;
	// a size of zero acts as one and a size above the maximum is clamped.
	function automatic logic is_last(input logic [15:0] pos, input logic [DIM_W-1:0] size,
			input int maxv);
		logic [15:0] eff;
		if (size == '0) begin
			eff = 16'd1;
		end else if (16'(size) > 16'(maxv)) begin
			eff = 16'(maxv);
		end else begin
			eff = 16'(size);
		end
		return (pos + 16'd1) >= eff;
	endfunction

	function automatic logic in_range(input pix_t v, input pix_t first,
			input logic [LEN_W-1:0] len);
		logic [9:0] off;
		off = {{2{v[PIX_W-1]}}, v} - {{2{first[PIX_W-1]}}, first};
		return !off[9] && (off[8:0] < len);
	endfunction

	function automatic logic [PIX_W-1:0] abs_diff(input pix_t a, input pix_t b);
		logic [PIX_W:0] s;
		logic [PIX_W:0] m;
		s = {a[PIX_W-1], a} - {b[PIX_W-1], b};
		m = s[PIX_W] ? (~s + 1'b1) : s;
		return m[PIX_W-1:0];
	endfunction

	function automatic logic bucket_ok(input logic [PIX_W-1:0] d);
		return 32'(d) < 32'(BUCKETS);
	endfunction

endpackage

FILE: design/teh_if.sv
// Valid/ready channel interfaces for requests and read results.
// Depends on teh_pkg for field widths.
`timescale 1ns / 1ps

interface teh_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      req_type;
	logic signed [teh_pkg::PIX_W-1:0] pixel;
	logic [teh_pkg::IDX_W-1:0]       bucket;

	modport source(output valid, req_type, pixel, bucket, input ready);
	modport sink(input valid, req_type, pixel, bucket, output ready);
endinterface

interface teh_res_if;
	logic                      valid;
	logic                      ready;
	logic [teh_pkg::IDX_W-1:0] bucket_index;
	logic [teh_pkg::CNT_W-1:0] bin_count;

	modport source(output valid, bucket_index, bin_count, input ready);
	modport sink(input valid, bucket_index, bin_count, output ready);
endinterface

FILE: design/toroidal_edge_histogram.sv
// Top level of the toroidal edge histogram: row memories, histogram memory and sequencer.
// Depends on teh_pkg and the channel interfaces in teh_if.sv.
`timescale 1ns / 1ps

// A pixel transaction passes through ST_PIX and then one ST_INC step per counted neighbor
// pair, since the histogram memory performs one increment per cycle. A read transaction
// passes through ST_RDRES before its result enters the output register, and waits in
// ST_RDRES while an earlier result is still held there. Start and unused request codes
// leave the block idle. The histogram is cleared at once by a per-bucket valid flag, with
// no clearing pass. Configuration must be written only while the block is idle; the block does not enforce it.
module toroidal_edge_histogram (
	input  logic                          clk,
	input  logic                          arst_n,
	teh_req_if.sink                       req,
	teh_res_if.source                     res,
	input  logic                          cfg_we,
	input  logic [teh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [teh_pkg::CFG_W-1:0]     cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PIX   = 4'b0010,
		ST_INC   = 4'b0100,
		ST_RDRES = 4'b1000
	} state_t;

	state_t state_q;

	teh_pkg::pix_t                  range_first_q;
	logic [teh_pkg::LEN_W-1:0]      range_length_q;
	logic [teh_pkg::DIM_W-1:0]      image_width_q;
	logic [teh_pkg::DIM_W-1:0]      image_height_q;

	logic [teh_pkg::COL_W-1:0]      column_q;
	logic [teh_pkg::ROW_W-1:0]      row_q;
	teh_pkg::pix_t                  row_start_q;
	teh_pkg::pix_t                  last_pix_q;

	teh_pkg::pix_t                  prev_mem [teh_pkg::MAX_WIDTH];
	teh_pkg::pix_t                  first_mem [teh_pkg::MAX_WIDTH];
	logic [teh_pkg::CNT_W-1:0]      hist_mem [teh_pkg::BUCKETS];

	teh_pkg::pix_t                  pix_s1;
	teh_pkg::pix_t                  left_s1;
	teh_pkg::pix_t                  rsp_s1;
	teh_pkg::pix_t                  prev_rd_s1;
	teh_pkg::pix_t                  first_rd_s1;
	logic                           left_en_s1;
	logic                           wrap_en_s1;
	logic                           vert_en_s1;
	logic                           fwrap_en_s1;
	logic                           row0_s1;

	logic [teh_pkg::PAIRS-1:0]      pend_q;
	logic [teh_pkg::BKT_W-1:0]      dif_q [teh_pkg::PAIRS];

	logic [teh_pkg::BUCKETS-1:0]    hist_vld_q;
	logic [teh_pkg::CNT_W-1:0]      hist_rd_q;
	logic                           hist_hit_q;
	logic                           rmw_v_q;
	logic [teh_pkg::BKT_W-1:0]      rmw_addr_q;
	logic                           fwd_q;
	logic [teh_pkg::CNT_W-1:0]      fwd_val_q;
	logic                           rd_oob_q;
	logic [teh_pkg::IDX_W-1:0]      rd_bucket_q;

	logic                           out_valid_q;
	logic [teh_pkg::IDX_W-1:0]      out_bucket_q;
	logic [teh_pkg::CNT_W-1:0]      out_count_q;

	logic                           req_acc;
	logic                           pix_acc;
	logic                           rd_acc;
	logic                           start_acc;
	logic                           last_col;
	logic                           last_row;
	logic                           col0;
	logic                           row0;

	teh_pkg::pix_t                  pa [teh_pkg::PAIRS];
	teh_pkg::pix_t                  pb [teh_pkg::PAIRS];
	logic [teh_pkg::PAIRS-1:0]      pen;
	logic [teh_pkg::PAIRS-1:0]      cnt_n;
	logic [teh_pkg::BKT_W-1:0]      dif_n [teh_pkg::PAIRS];
	logic [teh_pkg::PIX_W-1:0]      dabs [teh_pkg::PAIRS];

	logic [1:0]                     sel;
	logic [teh_pkg::PAIRS-1:0]      pend_left;
	logic                           inc_issue;
	logic                           hist_re;
	logic [teh_pkg::BKT_W-1:0]      hist_ra;
	logic [teh_pkg::CNT_W-1:0]      base;
	logic [teh_pkg::CNT_W-1:0]      wval;
	logic                           out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign pix_acc   = req_acc && (req.req_type == teh_pkg::REQ_PIXEL);
	assign rd_acc    = req_acc && (req.req_type == teh_pkg::REQ_READ);
	assign start_acc = req_acc && (req.req_type == teh_pkg::REQ_START);

	assign last_col = teh_pkg::is_last(16'(column_q), image_width_q, teh_pkg::MAX_WIDTH);
	assign last_row = teh_pkg::is_last(16'(row_q), image_height_q, teh_pkg::MAX_HEIGHT);
	assign col0     = (column_q == '0);
	assign row0     = (row_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q  <= 8'sh80;
			range_length_q <= 9'd256;
			image_width_q  <= 11'd1024;
			image_height_q <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				teh_pkg::CFG_RANGE_FIRST:  range_first_q  <= cfg_data[teh_pkg::PIX_W-1:0];
				teh_pkg::CFG_RANGE_LENGTH: range_length_q <= cfg_data[teh_pkg::LEN_W-1:0];
				teh_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[teh_pkg::DIM_W-1:0];
				teh_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[teh_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			row_q       <= '0;
			row_start_q <= '0;
		end else if (start_acc) begin
			column_q    <= '0;
			row_q       <= '0;
			row_start_q <= '0;
		end else if (pix_acc) begin
			if (col0) begin
				row_start_q <= req.pixel;
			end
			if (last_col) begin
				column_q <= '0;
				row_q    <= last_row ? '0 : row_q + 1'b1;
			end else begin
				column_q <= column_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			last_pix_q  <= req.pixel;
			pix_s1      <= req.pixel;
			left_s1     <= last_pix_q;
			rsp_s1      <= col0 ? req.pixel : row_start_q;
			left_en_s1  <= !col0;
			wrap_en_s1  <= last_col;
			vert_en_s1  <= !row0;
			fwrap_en_s1 <= last_row;
			row0_s1     <= row0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			prev_rd_s1         <= prev_mem[column_q];
			prev_mem[column_q] <= req.pixel;
			first_rd_s1        <= first_mem[column_q];
			if (row0) begin
				first_mem[column_q] <= req.pixel;
			end
		end
	end

	always_comb begin
		pa[0]  = left_s1;
		pb[0]  = pix_s1;
		pen[0] = left_en_s1;
		pa[1]  = pix_s1;
		pb[1]  = rsp_s1;
		pen[1] = wrap_en_s1;
		pa[2]  = prev_rd_s1;
		pb[2]  = pix_s1;
		pen[2] = vert_en_s1;
		pa[3]  = pix_s1;
		pb[3]  = row0_s1 ? pix_s1 : first_rd_s1;
		pen[3] = fwrap_en_s1;
		for (int i = 0; i < teh_pkg::PAIRS; i++) begin
			dabs[i]  = teh_pkg::abs_diff(pa[i], pb[i]);
			dif_n[i] = dabs[i][teh_pkg::BKT_W-1:0];
			cnt_n[i] = pen[i]
				&& teh_pkg::in_range(pa[i], range_first_q, range_length_q)
				&& teh_pkg::in_range(pb[i], range_first_q, range_length_q)
				&& teh_pkg::bucket_ok(dabs[i]);
		end
	end

	always_comb begin
		sel = '0;
		for (int i = teh_pkg::PAIRS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = 2'(i);
			end
		end
	end

	assign pend_left = pend_q & ~(teh_pkg::PAIRS'(1) << sel);
	assign inc_issue = (state_q == ST_INC);
	assign hist_re   = inc_issue || rd_acc;
	assign hist_ra   = inc_issue ? dif_q[sel] : req.bucket[teh_pkg::BKT_W-1:0];

	assign base = fwd_q ? fwd_val_q : (hist_hit_q ? hist_rd_q : '0);
	assign wval = (base == teh_pkg::COUNT_MAX) ? base : base + 1'b1;

	always_ff @(posedge clk) begin
		if (state_q == ST_PIX) begin
			dif_q <= dif_n;
		end
	end

	always_ff @(posedge clk) begin
		if (hist_re) begin
			hist_rd_q  <= hist_mem[hist_ra];
			hist_hit_q <= hist_vld_q[hist_ra];
			rmw_addr_q <= hist_ra;
			fwd_val_q  <= wval;
		end
		if (rmw_v_q) begin
			hist_mem[rmw_addr_q] <= wval;
		end
		if (rd_acc) begin
			rd_bucket_q <= req.bucket;
			rd_oob_q    <= 32'(req.bucket) >= 32'(teh_pkg::BUCKETS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmw_v_q    <= 1'b0;
			fwd_q      <= 1'b0;
			hist_vld_q <= '0;
		end else begin
			rmw_v_q <= inc_issue;
			if (hist_re) begin
				fwd_q <= rmw_v_q && (rmw_addr_q == hist_ra);
			end
			if (start_acc) begin
				hist_vld_q <= '0;
			end else if (rmw_v_q) begin
				hist_vld_q[rmw_addr_q] <= 1'b1;
			end
		end
	end

	assign out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						state_q <= ST_PIX;
					end else if (rd_acc) begin
						state_q <= ST_RDRES;
					end
				end
				ST_PIX: begin
					pend_q  <= cnt_n;
					state_q <= (cnt_n != '0) ? ST_INC : ST_IDLE;
				end
				ST_INC: begin
					pend_q <= pend_left;
					if (pend_left == '0) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RDRES: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RDRES) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RDRES) && out_free) begin
			out_bucket_q <= rd_bucket_q;
			out_count_q  <= rd_oob_q ? '0 : base;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.bucket_index = out_bucket_q;
	assign res.bin_count    = out_count_q;

endmodule

FILE: design/teh_checker.sv
// Port-level checker for the toroidal edge histogram and the bind that attaches it.
// Depends on teh_pkg and the toroidal_edge_histogram top level.
`timescale 1ns / 1ps

module teh_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_ready,
	input logic [1:0]                req_type,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [teh_pkg::IDX_W-1:0] bucket_index,
	input logic [teh_pkg::CNT_W-1:0] bin_count
);

	// A result that is not taken stays unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(bucket_index) && $stable(bin_count))
		else $error("result changed while stalled");

	// A read transaction keeps the request side closed while its count is fetched.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == teh_pkg::REQ_READ) |=> !req_ready)
		else $error("request accepted during a bucket read");

	// A pixel transaction keeps the request side closed while its row memory read data are used.
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == teh_pkg::REQ_PIXEL) |=> !req_ready)
		else $error("request accepted right after a pixel");

	// A new result appears only at the end of a read, while requests are held off.
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!req_ready))
		else $error("result appeared without a pending read");

endmodule

bind toroidal_edge_histogram teh_checker u_teh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_type     (req.req_type),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.bucket_index (res.bucket_index),
	.bin_count    (res.bin_count)
);
